[sv/ffba_pkg.sv]
// Package for the first-fit box allocator.
// Holds the box count, derived widths, register indexes, the sequencer states
// and the request bundle between the sequencer and the space store.
package ffba_pkg;

  localparam int NumBoxes = 16;
  localparam int IdxW = (NumBoxes > 1) ? $clog2(NumBoxes) : 1;
  localparam int CntW = $clog2(NumBoxes + 1);

  localparam int SizeW = 8;
  localparam int CapW = 8;
  localparam int BoxCountW = 5;
  localparam int CfgDataW = 8;
  localparam int CfgIdxW = 1;
  localparam int OutIdxW = 4;
  localparam int OutUsedW = 5;

  localparam logic [CapW-1:0] CapacityAtReset = CapW'(5);
  localparam logic [BoxCountW-1:0] CountAtReset = BoxCountW'(16);

  localparam logic [CfgIdxW-1:0] RegBoxCapacity = 1'b0;
  localparam logic [CfgIdxW-1:0] RegBoxCount = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StHold
  } state_e;

  typedef struct packed {
    logic            refill;
    logic [CapW-1:0] level;
    logic [IdxW-1:0] rd_idx;
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic [CapW-1:0] wr_data;
  } store_req_t;

endpackage

[sv/ffba_space_store.sv]
// Remaining space of every box, one register per box with a written flag.
// A refill clears all flags at once and records the new level; an unwritten
// box reads as that level. Depends on ffba_pkg.
module ffba_space_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ffba_pkg::store_req_t            req_i,
  output logic [ffba_pkg::CapW-1:0]       rd_space_o
);

  logic [ffba_pkg::CapW-1:0]     space_q [ffba_pkg::NumBoxes];
  logic [ffba_pkg::NumBoxes-1:0] written_q;
  logic [ffba_pkg::CapW-1:0]     level_q;

  assign rd_space_o = written_q[req_i.rd_idx] ? space_q[req_i.rd_idx] : level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      level_q   <= ffba_pkg::CapacityAtReset;
    end else if (req_i.refill) begin
      written_q <= '0;
      level_q   <= req_i.level;
    end else if (req_i.wr_en) begin
      written_q[req_i.wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!req_i.refill && req_i.wr_en) begin
      space_q[req_i.wr_idx] <= req_i.wr_data;
    end
  end

endmodule

[sv/ffba_seq.sv]
// Sequencer for the first-fit search: one compare and subtract unit walks the
// boxes one per cycle, then the result is held in an output register.
// Depends on ffba_pkg.
module ffba_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ffba_pkg::CapW-1:0]          box_capacity_i,
  input  logic [ffba_pkg::BoxCountW-1:0]     box_count_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ffba_pkg::SizeW-1:0]         item_size_i,
  input  logic                               new_batch_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               placed_o,
  output logic [ffba_pkg::OutIdxW-1:0]       box_index_o,
  output logic [ffba_pkg::CapW-1:0]          space_left_o,
  output logic [ffba_pkg::OutUsedW-1:0]      boxes_used_o,
  output ffba_pkg::store_req_t               store_req_o,
  input  logic [ffba_pkg::CapW-1:0]          rd_space_i
);

  ffba_pkg::state_e state_q, state_d;

  logic [ffba_pkg::SizeW-1:0] size_q, size_d;
  logic [ffba_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [ffba_pkg::CntW-1:0]  limit_q, limit_d;
  logic [ffba_pkg::CntW-1:0]  used_q, used_d;
  logic                       res_placed_q, res_placed_d;
  logic [ffba_pkg::IdxW-1:0]  res_idx_q, res_idx_d;
  logic [ffba_pkg::CapW-1:0]  res_left_q, res_left_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_placed_q, out_placed_d;
  logic [ffba_pkg::IdxW-1:0]  out_idx_q, out_idx_d;
  logic [ffba_pkg::CapW-1:0]  out_left_q, out_left_d;
  logic [ffba_pkg::CntW-1:0]  out_used_q, out_used_d;

  logic                       in_fire;
  logic                       out_free;
  logic                       fits;
  logic [ffba_pkg::CapW-1:0]  diff;
  logic                       last_box;
  logic [ffba_pkg::CntW-1:0]  limit_in;
  logic [ffba_pkg::CntW-1:0]  next_used;

  assign in_fire  = in_valid_i && (state_q == ffba_pkg::StIdle);
  assign out_free = !out_valid_q || out_ready_i;

  assign fits      = ({1'b0, size_q} <= {1'b0, rd_space_i});
  assign diff      = rd_space_i - size_q;
  assign last_box  = (ffba_pkg::CntW'(idx_q) + ffba_pkg::CntW'(1)) == limit_q;
  assign next_used = ffba_pkg::CntW'(idx_q) + ffba_pkg::CntW'(1);
  assign limit_in  = (32'(box_count_i) > 32'(ffba_pkg::NumBoxes)) ?
                     ffba_pkg::CntW'(ffba_pkg::NumBoxes) : ffba_pkg::CntW'(box_count_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffba_pkg::StIdle: begin
        if (in_fire) begin
          state_d = (limit_in == '0) ? ffba_pkg::StHold : ffba_pkg::StScan;
        end
      end
      ffba_pkg::StScan: begin
        if (fits || last_box) begin
          state_d = ffba_pkg::StHold;
        end
      end
      ffba_pkg::StHold: begin
        if (out_free) begin
          state_d = ffba_pkg::StIdle;
        end
      end
      default: state_d = ffba_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o           = (state_q == ffba_pkg::StIdle);
    store_req_o.refill   = in_fire && new_batch_i;
    store_req_o.level    = box_capacity_i;
    store_req_o.rd_idx   = idx_q;
    store_req_o.wr_en    = (state_q == ffba_pkg::StScan) && fits;
    store_req_o.wr_idx   = idx_q;
    store_req_o.wr_data  = diff;
  end

  always_comb begin
    size_d       = size_q;
    idx_d        = idx_q;
    limit_d      = limit_q;
    used_d       = used_q;
    res_placed_d = res_placed_q;
    res_idx_d    = res_idx_q;
    res_left_d   = res_left_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_placed_d = out_placed_q;
    out_idx_d    = out_idx_q;
    out_left_d   = out_left_q;
    out_used_d   = out_used_q;
    case (state_q)
      ffba_pkg::StIdle: begin
        if (in_fire) begin
          size_d       = item_size_i;
          idx_d        = '0;
          limit_d      = limit_in;
          res_placed_d = 1'b0;
          res_idx_d    = '0;
          res_left_d   = '0;
          if (new_batch_i) begin
            used_d = '0;
          end
        end
      end
      ffba_pkg::StScan: begin
        if (fits) begin
          res_placed_d = 1'b1;
          res_idx_d    = idx_q;
          res_left_d   = diff;
          if (next_used > used_q) begin
            used_d = next_used;
          end
        end else if (!last_box) begin
          idx_d = idx_q + ffba_pkg::IdxW'(1);
        end
      end
      ffba_pkg::StHold: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_placed_d = res_placed_q;
          out_idx_d    = res_idx_q;
          out_left_d   = res_left_q;
          out_used_d   = used_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::StIdle;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q       <= size_d;
    idx_q        <= idx_d;
    limit_q      <= limit_d;
    res_placed_q <= res_placed_d;
    res_idx_q    <= res_idx_d;
    res_left_q   <= res_left_d;
    out_placed_q <= out_placed_d;
    out_idx_q    <= out_idx_d;
    out_left_q   <= out_left_d;
    out_used_q   <= out_used_d;
  end

  assign out_valid_o  = out_valid_q;
  assign placed_o     = out_placed_q;
  assign box_index_o  = ffba_pkg::OutIdxW'(out_idx_q);
  assign space_left_o = out_left_q;
  assign boxes_used_o = ffba_pkg::OutUsedW'(out_used_q);

endmodule

[sv/first_fit_bin_allocator.sv]
// Top level of the first-fit box allocator: configuration registers, the
// search sequencer and the box space store. Depends on ffba_pkg, ffba_seq
// and ffba_space_store.
//
//   Channel  Direction  Handshake              Contents
//   cfg      in         cfg_we_i               cfg_idx_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o  item_size_i, new_batch_i
//   out      out        out_valid_o/out_ready_i placed_o, box_index_o,
//                                              space_left_o, boxes_used_o
//
// A word is taken in StIdle, the boxes are searched in turn in StScan up to the
// box count, and the result waits in StHold until the output register is free;
// the search runs on the single compare and subtract unit.
// A new batch refills every box in the cycle the word is taken.
// Reset fills every box to a capacity of five and clears the used count.
// A stalled output holds its word while the next input word is taken.
module first_fit_bin_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ffba_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ffba_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ffba_pkg::SizeW-1:0]        item_size_i,
  input  logic                              new_batch_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              placed_o,
  output logic [ffba_pkg::OutIdxW-1:0]      box_index_o,
  output logic [ffba_pkg::CapW-1:0]         space_left_o,
  output logic [ffba_pkg::OutUsedW-1:0]     boxes_used_o
);

  logic [ffba_pkg::CapW-1:0]      box_capacity_q;
  logic [ffba_pkg::BoxCountW-1:0] box_count_q;
  ffba_pkg::store_req_t           store_req;
  logic [ffba_pkg::CapW-1:0]      rd_space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_capacity_q <= ffba_pkg::CapacityAtReset;
      box_count_q    <= ffba_pkg::CountAtReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffba_pkg::RegBoxCapacity: box_capacity_q <= ffba_pkg::CapW'(cfg_data_i);
        ffba_pkg::RegBoxCount:    box_count_q    <= ffba_pkg::BoxCountW'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  ffba_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .box_capacity_i (box_capacity_q),
    .box_count_i    (box_count_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .item_size_i    (item_size_i),
    .new_batch_i    (new_batch_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .placed_o       (placed_o),
    .box_index_o    (box_index_o),
    .space_left_o   (space_left_o),
    .boxes_used_o   (boxes_used_o),
    .store_req_o    (store_req),
    .rd_space_i     (rd_space)
  );

  ffba_space_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (store_req),
    .rd_space_o (rd_space)
  );

endmodule

[tb/first_fit_bin_allocator_tb.sv]
`timescale 1ns / 100ps
// Testbench for first_fit_bin_allocator: directed and random words checked against a
// first-fit predictor of the box spaces. Depends on ffba_pkg and the allocator RTL.
module first_fit_bin_allocator_tb;

  typedef struct packed {
    logic                          placed;
    logic [ffba_pkg::OutIdxW-1:0]  index;
    logic [ffba_pkg::CapW-1:0]     left;
    logic [ffba_pkg::OutUsedW-1:0] used;
  } placement_t;

  typedef enum {RxAlways, RxRandom, RxPattern} rx_mode_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [ffba_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [ffba_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [ffba_pkg::SizeW-1:0]    item_size_i = '0;
  logic                          new_batch_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          placed_o;
  logic [ffba_pkg::OutIdxW-1:0]  box_index_o;
  logic [ffba_pkg::CapW-1:0]     space_left_o;
  logic [ffba_pkg::OutUsedW-1:0] boxes_used_o;

  placement_t                     pending_placements[$];
  logic [ffba_pkg::CapW-1:0]      box_space[ffba_pkg::NumBoxes];
  int unsigned                    boxes_taken = 0;
  logic [ffba_pkg::CapW-1:0]      box_capacity = ffba_pkg::CapacityAtReset;
  logic [ffba_pkg::BoxCountW-1:0] boxes_searched = ffba_pkg::CountAtReset;
  int unsigned                    mismatches = 0;
  int unsigned                    hold_cycles = 0;
  int unsigned                    rx_tick = 0;
  rx_mode_e                       rx_mode = RxAlways;
  bit                             tx_bursty = 1'b0;

  first_fit_bin_allocator DUT (.*);

  always #4 clk_i = ~clk_i;

  function automatic placement_t place_item(input logic [ffba_pkg::SizeW-1:0] size,
                                            input logic batch);
    placement_t  res;
    int unsigned limit;
    res = '0;
    if (batch) begin
      foreach (box_space[b]) box_space[b] = box_capacity;
      boxes_taken = 0;
    end
    limit = (boxes_searched > ffba_pkg::NumBoxes) ? ffba_pkg::NumBoxes : boxes_searched;
    for (int b = 0; b < limit; b++) begin
      if (size <= box_space[b]) begin
        box_space[b] = box_space[b] - size;
        res.placed = 1'b1;
        res.index = ffba_pkg::OutIdxW'(b);
        res.left = box_space[b];
        if (b + 1 > boxes_taken) boxes_taken = b + 1;
        break;
      end
    end
    res.used = ffba_pkg::OutUsedW'(boxes_taken);
    return res;
  endfunction

  function automatic logic [ffba_pkg::SizeW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ffba_pkg::SizeW'($urandom_range(0, 255));
      2: return box_capacity;
      3: return box_capacity + 8'd1;
      default: return ffba_pkg::SizeW'($urandom_range(0, box_capacity));
    endcase
  endfunction

  task automatic send_word(input logic [ffba_pkg::SizeW-1:0] size, input logic batch);
    in_valid_i <= 1'b1;
    item_size_i <= size;
    new_batch_i <= batch;
    do @(posedge clk_i); while (!in_ready_o);
    pending_placements.push_back(place_item(size, batch));
  endtask

  task automatic idle_gap(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_placements.size() != 0);
  endtask

  task automatic set_boxes(input logic [ffba_pkg::CfgDataW-1:0] capacity,
                           input logic [ffba_pkg::CfgDataW-1:0] count);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ffba_pkg::RegBoxCapacity;
    cfg_data_i <= capacity;
    @(posedge clk_i);
    box_capacity = capacity;
    cfg_idx_i <= ffba_pkg::RegBoxCount;
    cfg_data_i <= count;
    @(posedge clk_i);
    boxes_searched = count[ffba_pkg::BoxCountW-1:0];
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(input int unsigned words);
    int unsigned burst;
    burst = $urandom_range(1, 20);
    repeat (words) begin
      if (tx_bursty && burst == 0) begin
        idle_gap($urandom_range(1, 8));
        burst = $urandom_range(1, 20);
      end
      send_word(pick_size(), $urandom_range(0, 9) == 0);
      if (burst > 0) burst--;
    end
  endtask

  // Boxes still hold the reset capacity of five; no batch is started.
  task automatic test_reset_state();
    send_word(8'd0, 1'b0);
    send_word(8'd5, 1'b0);
    send_word(8'd6, 1'b0);
    send_word(8'd4, 1'b0);
  endtask

  // A count above the built boxes is limited, so the last word finds every box full.
  task automatic test_full_boxes();
    set_boxes(8'd1, 8'd31);
    send_word(8'd1, 1'b1);
    repeat (15) send_word(8'd1, 1'b0);
    send_word(8'd1, 1'b0);
  endtask

  task automatic test_extremes();
    set_boxes(8'd255, 8'd1);
    send_word(8'd255, 1'b1);
    send_word(8'd1, 1'b0);
    set_boxes(8'd9, 8'd0);
    send_word(8'd0, 1'b0);
    set_boxes(8'd9, 8'd2);
    send_word(8'd200, 1'b0);
    send_word(8'd9, 1'b1);
  endtask

  task automatic test_random_batches();
    logic [ffba_pkg::CfgDataW-1:0] capacity;
    logic [ffba_pkg::CfgDataW-1:0] count;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 7))
        0: capacity = 8'd0;
        1: capacity = 8'd1;
        2: capacity = 8'd255;
        3, 4: capacity = ffba_pkg::CfgDataW'($urandom_range(2, 12));
        default: capacity = ffba_pkg::CfgDataW'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 7))
        0: count = 8'd0;
        1: count = 8'd1;
        2: count = 8'd16;
        3: count = ffba_pkg::CfgDataW'($urandom_range(17, 31));
        default: count = ffba_pkg::CfgDataW'($urandom_range(1, 16));
      endcase
      set_boxes(capacity, count);
      rx_mode = rx_mode_e'(phase % 3);
      tx_bursty = (phase % 4) != 0;
      send_word(pick_size(), 1'b1);
      send_random(150);
    end
  endtask

  // The receiver holds off long enough for the allocator to stall its input.
  task automatic test_backpressure();
    set_boxes(8'd20, 8'd16);
    rx_mode = RxRandom;
    tx_bursty = 1'b0;
    hold_cycles = 400;
    send_word(pick_size(), 1'b1);
    send_random(60);
    wait_drained();
    tx_bursty = 1'b1;
    send_random(40);
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RxAlways: out_ready_i <= 1'b1;
        RxRandom: out_ready_i <= $urandom_range(0, 3) != 0;
        default: out_ready_i <= (rx_tick % 7) < 4;
      endcase
    end
    rx_tick++;
  end

  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_placements.size() == 0) begin
        mismatches++;
        $display("%0t: word with none expected: placed %0d box %0d space %0d used %0d",
                 $time, placed_o, box_index_o, space_left_o, boxes_used_o);
      end else begin
        want = pending_placements.pop_front();
        if (placed_o !== want.placed) begin
          mismatches++;
          $display("%0t: placed expected %0d, got %0d", $time, want.placed, placed_o);
        end
        if (box_index_o !== want.index) begin
          mismatches++;
          $display("%0t: box_index expected %0d, got %0d", $time, want.index, box_index_o);
        end
        if (space_left_o !== want.left) begin
          mismatches++;
          $display("%0t: space_left expected %0d, got %0d", $time, want.left, space_left_o);
        end
        if (boxes_used_o !== want.used) begin
          mismatches++;
          $display("%0t: boxes_used expected %0d, got %0d", $time, want.used, boxes_used_o);
        end
      end
    end
  end

  initial begin
    foreach (box_space[b]) box_space[b] = ffba_pkg::CapacityAtReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_full_boxes();
    test_extremes();
    test_random_batches();
    test_backpressure();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
